@@ src/rmd_pkg.sv @@
`default_nettype none

package rmd_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned REG_BITS  = 5;
    localparam int unsigned DIV_STEPS = 32;

    typedef enum logic [2:0] {
        F3_MUL    = 3'b000,
        F3_MULH   = 3'b001,
        F3_MULHSU = 3'b010,
        F3_MULHU  = 3'b011,
        F3_DIV    = 3'b100,
        F3_DIVU   = 3'b101,
        F3_REM    = 3'b110,
        F3_REMU   = 3'b111
    } t_funct3;

    localparam logic [XLEN-1:0] ALL_ONES = {XLEN{1'b1}};

    // Payload carried down the divider pipeline.
    typedef struct packed {
        t_funct3               action;
        logic [REG_BITS-1:0]   dest;
        logic [XLEN-1:0]       rem;
        logic [XLEN-1:0]       quo;
        logic [XLEN-1:0]       dvs;
        logic                  neg_q;
        logic                  neg_r;
        logic                  b_zero;
        logic [XLEN-1:0]       mul_hi;
        logic [XLEN-1:0]       mul_corr;
    } t_div_pl;

    // Stage control: valid travels with the payload, enable comes from the tail.
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

`default_nettype wire

@@ src/rmd_if.sv @@
`default_nettype none

interface rmd_op_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [4:0]  dest_in;

    modport source (output valid, output action, output operand_a, output operand_b,
                    output dest_in, input ready);
    modport sink   (input valid, input action, input operand_a, input operand_b,
                    input dest_in, output ready);
endinterface

interface rmd_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic [4:0]  dest_out;
    logic        unsupported;

    modport source (output valid, output result, output dest_out, output unsupported,
                    input ready);
    modport sink   (input valid, input result, input dest_out, input unsupported,
                    output ready);
endinterface

`default_nettype wire

@@ src/rv32m_mulhsu_divide_unit.sv @@
// An accepted transaction passes the operand stage, the divider stages and the
// result stage. A held result at the tail freezes the pipeline; a transaction
// parked in the input skid register enters on the next advancing cycle.
// Throughput: one transaction per cycle while the tail is not held; the divider
// is 32 restoring stages, one quotient bit each, between operand and result stages.
// Reset (synchronous, active low) empties the pipeline and the skid register.
`default_nettype none

module rv32m_mulhsu_divide_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rmd_op_if.sink      i_op,
    rmd_res_if.source   o_res
);

    logic                  w_en;
    logic                  w_out_valid;
    logic                  r_skid_valid;
    logic [2:0]            r_skid_action;
    logic [31:0]           r_skid_a;
    logic [31:0]           r_skid_b;
    logic [4:0]            r_skid_dest;
    rmd_pkg::t_stage_ctl   w_front_ctl;
    logic [2:0]            w_action;
    logic [31:0]           w_a;
    logic [31:0]           w_b;
    logic [4:0]            w_dest;

    logic                  w_valid [0:rmd_pkg::DIV_STEPS];
    rmd_pkg::t_div_pl      w_pl    [0:rmd_pkg::DIV_STEPS];
    rmd_pkg::t_stage_ctl   w_ctl   [0:rmd_pkg::DIV_STEPS];

    // Advance the whole pipeline unless a finished result is held at the tail.
    assign w_en = !w_out_valid || o_res.ready;

    assign i_op.ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= 1'b0;
        end else if (i_op.valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && !r_skid_valid) begin
            r_skid_action <= i_op.action;
            r_skid_a      <= i_op.operand_a;
            r_skid_b      <= i_op.operand_b;
            r_skid_dest   <= i_op.dest_in;
        end
    end

    // Drain the skid register first; otherwise take the live transaction.
    assign w_front_ctl.en    = w_en;
    assign w_front_ctl.valid = r_skid_valid || i_op.valid;
    assign w_action = r_skid_valid ? r_skid_action : i_op.action;
    assign w_a      = r_skid_valid ? r_skid_a      : i_op.operand_a;
    assign w_b      = r_skid_valid ? r_skid_b      : i_op.operand_b;
    assign w_dest   = r_skid_valid ? r_skid_dest   : i_op.dest_in;

    rmd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_front_ctl),
        .i_action    (w_action),
        .i_operand_a (w_a),
        .i_operand_b (w_b),
        .i_dest      (w_dest),
        .o_valid     (w_valid[0]),
        .o_pl        (w_pl[0])
    );

    genvar g;
    generate
        for (g = 0; g < rmd_pkg::DIV_STEPS; g++) begin : g_step
            assign w_ctl[g].en    = w_en;
            assign w_ctl[g].valid = w_valid[g];

            rmd_div_stage u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[g]),
                .i_pl    (w_pl[g]),
                .o_valid (w_valid[g+1]),
                .o_pl    (w_pl[g+1])
            );
        end
    endgenerate

    assign w_ctl[rmd_pkg::DIV_STEPS].en    = w_en;
    assign w_ctl[rmd_pkg::DIV_STEPS].valid = w_valid[rmd_pkg::DIV_STEPS];

    rmd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl[rmd_pkg::DIV_STEPS]),
        .i_pl          (w_pl[rmd_pkg::DIV_STEPS]),
        .o_valid       (w_out_valid),
        .o_result      (o_res.result),
        .o_dest        (o_res.dest_out),
        .o_unsupported (o_res.unsupported)
    );

    assign o_res.valid = w_out_valid;

endmodule

`default_nettype wire

@@ src/rmd_front.sv @@
`default_nettype none

module rmd_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire rmd_pkg::t_stage_ctl      i_ctl,
    input  wire logic [2:0]               i_action,
    input  wire logic [31:0]              i_operand_a,
    input  wire logic [31:0]              i_operand_b,
    input  wire logic [4:0]               i_dest,
    output      logic                     o_valid,
    output      rmd_pkg::t_div_pl         o_pl
);

    logic                 r_valid;
    rmd_pkg::t_div_pl     r_pl;
    rmd_pkg::t_div_pl     n_pl;
    rmd_pkg::t_funct3     w_f3;
    logic                 w_signed;
    logic [63:0]          w_prod;

    assign w_f3     = rmd_pkg::t_funct3'(i_action);
    assign w_signed = (w_f3 == rmd_pkg::F3_DIV) || (w_f3 == rmd_pkg::F3_REM);
    assign w_prod   = {32'd0, i_operand_a} * {32'd0, i_operand_b};

    always_comb begin
        n_pl          = '0;
        n_pl.action   = w_f3;
        n_pl.dest     = i_dest;
        n_pl.rem      = '0;
        // Divide magnitudes for signed codes; signs are restored at the tail.
        n_pl.quo      = (w_signed && i_operand_a[31]) ? (32'd0 - i_operand_a) : i_operand_a;
        n_pl.dvs      = (w_signed && i_operand_b[31]) ? (32'd0 - i_operand_b) : i_operand_b;
        n_pl.neg_q    = w_signed && (i_operand_a[31] ^ i_operand_b[31]);
        n_pl.neg_r    = w_signed && i_operand_a[31];
        n_pl.b_zero   = (i_operand_b == 32'd0);
        n_pl.mul_hi   = w_prod[63:32];
        // Signed multiplicand: subtract b * 2^32 when a is negative.
        n_pl.mul_corr = i_operand_a[31] ? i_operand_b : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_pl <= n_pl;
        end
    end

    assign o_valid = r_valid;
    assign o_pl    = r_pl;

endmodule

`default_nettype wire

@@ src/rmd_div_stage.sv @@
`default_nettype none

module rmd_div_stage (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire rmd_pkg::t_stage_ctl      i_ctl,
    input  wire rmd_pkg::t_div_pl         i_pl,
    output      logic                     o_valid,
    output      rmd_pkg::t_div_pl         o_pl
);

    logic                 r_valid;
    rmd_pkg::t_div_pl     r_pl;
    rmd_pkg::t_div_pl     n_pl;
    logic [32:0]          w_part;
    logic [32:0]          w_trial;

    // One restoring step: bring down the next dividend bit and try the subtract.
    assign w_part  = {i_pl.rem, i_pl.quo[31]};
    assign w_trial = w_part - {1'b0, i_pl.dvs};

    always_comb begin
        n_pl = i_pl;
        if (!w_trial[32]) begin
            n_pl.rem = w_trial[31:0];
            n_pl.quo = {i_pl.quo[30:0], 1'b1};
        end else begin
            n_pl.rem = w_part[31:0];
            n_pl.quo = {i_pl.quo[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_pl <= n_pl;
        end
    end

    assign o_valid = r_valid;
    assign o_pl    = r_pl;

endmodule

`default_nettype wire

@@ src/rmd_back.sv @@
`default_nettype none

module rmd_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire rmd_pkg::t_stage_ctl      i_ctl,
    input  wire rmd_pkg::t_div_pl         i_pl,
    output      logic                     o_valid,
    output      logic [31:0]              o_result,
    output      logic [4:0]               o_dest,
    output      logic                     o_unsupported
);

    logic          r_valid;
    logic [31:0]   r_result;
    logic [4:0]    r_dest;
    logic          r_unsup;
    logic [31:0]   n_result;
    logic          n_unsup;
    logic [31:0]   w_quo_s;
    logic [31:0]   w_rem_s;

    assign w_quo_s = i_pl.neg_q ? (32'd0 - i_pl.quo) : i_pl.quo;
    assign w_rem_s = i_pl.neg_r ? (32'd0 - i_pl.rem) : i_pl.rem;

    always_comb begin
        n_result = '0;
        n_unsup  = 1'b0;
        case (i_pl.action)
            rmd_pkg::F3_MULHSU: n_result = i_pl.mul_hi - i_pl.mul_corr;
            // Zero divisor on a signed divide must not pick up the sign fix.
            rmd_pkg::F3_DIV:    n_result = i_pl.b_zero ? rmd_pkg::ALL_ONES : w_quo_s;
            rmd_pkg::F3_DIVU:   n_result = i_pl.quo;
            rmd_pkg::F3_REM:    n_result = w_rem_s;
            rmd_pkg::F3_REMU:   n_result = i_pl.rem;
            default: begin
                n_result = '0;
                n_unsup  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_result <= n_result;
            r_dest   <= i_pl.dest;
            r_unsup  <= n_unsup;
        end
    end

    assign o_valid       = r_valid;
    assign o_result      = r_result;
    assign o_dest        = r_dest;
    assign o_unsupported = r_unsup;

endmodule

`default_nettype wire
